// File: rtl/core/mdu_pkg.sv
// Package for the multiply/divide unit: operation codes, controller states
// and the word-size constants. No dependencies.
`default_nettype none

package mdu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(WORD_W - 1);
  localparam logic [WORD_W-1:0] RESET_WORD = 32'hdeadbeef;

  typedef enum logic [2:0] {
    OP_MULT  = 3'd0,
    OP_UMUL  = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MTHI  = 3'd4,
    OP_MTLO  = 3'd5,
    OP_MFHI  = 3'd6,
    OP_MFLO  = 3'd7
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX_LO,
    ST_FIX_HI,
    ST_FINISH
  } state_e;

endpackage : mdu_pkg

`default_nettype wire

// File: rtl/core/mips_multiply_divide_unit_top.sv
// Multiply/divide unit with HI and LO registers, single module.
// Depends on mdu_pkg for operation codes, states and word constants.
`default_nettype none

// One word is taken at a time. MULT/MULTU/DIV/DIVU run from acceptance to the
// next acceptance through a load step, 32 iterations of a bit-serial shift-add
// (multiply) or restoring shift-subtract (divide) loop over the HI:LO working
// pair, two sign-correction steps (LO half, then HI half with the carry) and
// the output-register load. MTHI/MTLO/MFHI/MFLO go from the load step to the
// output load. Unless the output stalls, the 32-iteration loop sets the rate.
// The output register is separate, so a new word is accepted while the last
// result still waits under stall. HI and LO reset to 0xdeadbeef.
module mips_multiply_divide_unit_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [2:0]                 req_type_i,
  input  wire  [31:0]                operand_a_i,
  input  wire  [31:0]                operand_b_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [31:0]                read_value_o,
  output logic [31:0]                hi_now_o,
  output logic [31:0]                lo_now_o
);
  import mdu_pkg::*;

  state_e           state_q, state_d;
  req_type_e        op_q, op_d, req_op;
  logic [31:0]      hi_q, hi_d, lo_q, lo_d;
  logic [31:0]      acc_q, acc_d, work_q, work_d, opb_q, opb_d;
  logic [31:0]      rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_lo_q, neg_lo_d, neg_hi_q, neg_hi_d, carry_q, carry_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_rd_q, out_hi_q, out_lo_q;

  logic             accept, can_load, load_out, is_mul;
  logic [31:0]      mag_a, mag_b;
  logic [32:0]      mul_sum, div_shift;
  logic [33:0]      div_diff;
  logic             div_ge;

  assign req_op   = req_type_e'(req_type_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign can_load = !out_valid_q || !out_stall_i;
  assign is_mul   = (op_q == OP_MULT) || (op_q == OP_UMUL);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_op == OP_MULT || req_op == OP_UMUL ||
              req_op == OP_DIV  || req_op == OP_DIVU) begin
            state_d = ST_CALC;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CALC: begin
        if (cnt_q == CNT_LAST) state_d = ST_FIX_LO;
      end
      ST_FIX_LO: state_d = ST_FIX_HI;
      ST_FIX_HI: state_d = ST_FINISH;
      ST_FINISH: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_FINISH: load_out   = can_load;
      default: begin
        in_stall_o = 1'b1;
        load_out   = 1'b0;
      end
    endcase
  end

  // Operand magnitudes for the signed forms
  assign mag_a = (req_op == OP_MULT || req_op == OP_DIV) && operand_a_i[31]
               ? ~operand_a_i + 32'd1 : operand_a_i;
  assign mag_b = (req_op == OP_MULT || req_op == OP_DIV) && operand_b_i[31]
               ? ~operand_b_i + 32'd1 : operand_b_i;

  // One multiply step: add multiplicand when the low bit is set, shift right
  assign mul_sum = {1'b0, acc_q} + (work_q[0] ? {1'b0, opb_q} : 33'd0);

  // One divide step: shift in the next dividend bit, subtract if it fits
  assign div_shift = {acc_q, work_q[31]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, opb_q};
  assign div_ge    = !div_diff[33];

  // Datapath
  always_comb begin
    op_d     = op_q;
    acc_d    = acc_q;
    work_d   = work_q;
    opb_d    = opb_q;
    rd_d     = rd_q;
    cnt_d    = cnt_q;
    neg_lo_d = neg_lo_q;
    neg_hi_d = neg_hi_q;
    carry_d  = carry_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = req_op;
          cnt_d    = '0;
          opb_d    = mag_b;
          rd_d     = '0;
          acc_d    = hi_q;
          work_d   = lo_q;
          neg_lo_d = 1'b0;
          neg_hi_d = 1'b0;
          unique case (req_op) inside
            OP_MULT: begin
              acc_d    = '0;
              work_d   = mag_a;
              neg_lo_d = operand_a_i[31] ^ operand_b_i[31];
              neg_hi_d = operand_a_i[31] ^ operand_b_i[31];
            end
            OP_DIV: begin
              acc_d    = '0;
              work_d   = mag_a;
              neg_lo_d = operand_a_i[31] ^ operand_b_i[31];
              neg_hi_d = operand_a_i[31];
            end
            OP_UMUL, OP_DIVU: begin
              acc_d  = '0;
              work_d = mag_a;
            end
            OP_MTHI: acc_d  = operand_a_i;
            OP_MTLO: work_d = operand_a_i;
            OP_MFHI: rd_d   = hi_q;
            OP_MFLO: rd_d   = lo_q;
            default: rd_d   = '0;
          endcase
        end
      end
      ST_CALC: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (is_mul) begin
          {acc_d, work_d} = {mul_sum, work_q[31:1]};
        end else begin
          acc_d  = div_ge ? div_diff[31:0] : div_shift[31:0];
          work_d = {work_q[30:0], div_ge};
        end
      end
      ST_FIX_LO: begin
        if (neg_lo_q) work_d = ~work_q + 32'd1;
        // a 64-bit negation carries into HI only when LO is zero
        carry_d = is_mul ? (work_q == 32'd0) : 1'b1;
      end
      ST_FIX_HI: begin
        if (neg_hi_q) acc_d = ~acc_q + {31'd0, carry_q};
      end
      ST_FINISH: begin
        if (can_load) begin
          hi_d = acc_q;
          lo_d = work_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= RESET_WORD;
      lo_q        <= RESET_WORD;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    acc_q    <= acc_d;
    work_q   <= work_d;
    opb_q    <= opb_d;
    rd_q     <= rd_d;
    cnt_q    <= cnt_d;
    neg_lo_q <= neg_lo_d;
    neg_hi_q <= neg_hi_d;
    carry_q  <= carry_d;
    if (load_out) begin
      out_rd_q <= rd_q;
      out_hi_q <= acc_q;
      out_lo_q <= work_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign hi_now_o     = out_hi_q;
  assign lo_now_o     = out_lo_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted word did not start the controller");

  a_loop_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && cnt_q == CNT_LAST |=> state_q == ST_FIX_LO)
    else $error("iteration loop did not end after the last bit");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC && (op_q == OP_DIV || op_q == OP_DIVU) && opb_q != 32'd0
      |-> acc_q < opb_q)
    else $error("partial remainder reached the divisor");

  a_result_matches_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && out_hi_q == hi_q && out_lo_q == lo_q)
    else $error("loaded result differs from HI/LO");

endmodule : mips_multiply_divide_unit_top

`default_nettype wire

// File: sim/tb_mips_multiply_divide_unit_top.sv
`timescale 1ns / 1ps
// Testbench for the multiply/divide unit: a queue-fed driver, a stalling monitor
// and an in-bench predictor of HI/LO. Depends on mdu_pkg and the unit's top level.

module tb_mips_multiply_divide_unit_top;
  import mdu_pkg::*;

  typedef struct {
    req_type_e   op;
    logic [31:0] a;
    logic [31:0] b;
    bit          drain_first;
  } mdu_word_t;

  typedef struct {
    logic [31:0] read_value;
    logic [31:0] hi;
    logic [31:0] lo;
  } hilo_result_t;

  localparam int unsigned NUM_RANDOM = 1500;
  localparam int unsigned CALM_TAIL  = 150;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic [2:0]  req_type   = '0;
  logic [31:0] operand_a  = '0;
  logic [31:0] operand_b  = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] read_value;
  logic [31:0] hi_now;
  logic [31:0] lo_now;

  mdu_word_t    pending_q[$];
  hilo_result_t expected_q[$];
  mdu_word_t    cur_word;
  logic [31:0]  hi_reg = RESET_WORD;
  logic [31:0]  lo_reg = RESET_WORD;
  int           n_total    = 0;
  int           n_accepted = 0;
  int           n_results  = 0;
  int           gap_left   = 0;
  int           stall_left = 0;
  int           err_cnt    = 0;

  always #10 clk_i = ~clk_i;

  mips_multiply_divide_unit_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .operand_a_i  (operand_a),
    .operand_b_i  (operand_b),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .hi_now_o     (hi_now),
    .lo_now_o     (lo_now)
  );

  // Apply one word to the HI/LO copy and return what the unit should report.
  function automatic hilo_result_t predict_hilo(mdu_word_t w);
    hilo_result_t    res;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic [63:0]     prod;
    res.read_value = '0;
    case (w.op)
      OP_MULT: begin
        sa = $signed(w.a);
        sb = $signed(w.b);
        prod = sa * sb;
        {hi_reg, lo_reg} = prod;
      end
      OP_UMUL: begin
        prod = {32'd0, w.a} * {32'd0, w.b};
        {hi_reg, lo_reg} = prod;
      end
      OP_DIV: begin
        if (w.b == 32'd0) begin
          hi_reg = w.a;
          lo_reg = w.a[31] ? 32'd1 : 32'hffffffff;
        end else if (w.a == 32'h80000000 && w.b == 32'hffffffff) begin
          hi_reg = 32'd0;
          lo_reg = 32'h80000000;
        end else begin
          lo_reg = $signed(w.a) / $signed(w.b);
          hi_reg = $signed(w.a) % $signed(w.b);
        end
      end
      OP_DIVU: begin
        if (w.b == 32'd0) begin
          hi_reg = w.a;
          lo_reg = 32'hffffffff;
        end else begin
          lo_reg = w.a / w.b;
          hi_reg = w.a % w.b;
        end
      end
      OP_MTHI: hi_reg = w.a;
      OP_MTLO: lo_reg = w.a;
      OP_MFHI: res.read_value = hi_reg;
      default: res.read_value = lo_reg;
    endcase
    res.hi = hi_reg;
    res.lo = lo_reg;
    return res;
  endfunction

  function automatic bit idling_on();
    return (n_accepted + CALM_TAIL < n_total) && ((n_accepted / 200) % 4 != 3);
  endfunction

  task automatic add_word(req_type_e op, logic [31:0] a, logic [31:0] b, bit drain = 1'b0);
    mdu_word_t w;
    w.op = op;
    w.a = a;
    w.b = b;
    w.drain_first = drain;
    pending_q.push_back(w);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hffffffff;
      3: return 32'h80000000;
      4: return 32'h7fffffff;
      5: return 32'($urandom_range(0, 255));
      6: return 32'd0 - 32'($urandom_range(1, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %08h, actual %08h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Driver: present the next word once the current one is taken.
  always @(posedge clk_i) begin : driver_proc
    bit           took;
    int           outstanding;
    mdu_word_t    w;
    hilo_result_t r;
    if (rst_ni) begin
      took = in_valid && !in_stall;
      if (took) begin
        r = predict_hilo(cur_word);
        expected_q.push_back(r);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || took) begin
        outstanding = n_accepted + int'(took) - n_results;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_q[0].drain_first && outstanding != 0) begin
          // hold until every result in flight has come back
          in_valid <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 12) - 1;
          in_valid <= 1'b0;
        end else begin
          w = pending_q.pop_front();
          cur_word = w;
          req_type  <= w.op;
          operand_a <= w.a;
          operand_b <= w.b;
          in_valid  <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin : monitor_proc
    hilo_result_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result: read_value %08h hi %08h lo %08h",
                 read_value, hi_now, lo_now);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          check_field("read_value", e.read_value, read_value);
          check_field("hi_now", e.hi, hi_now);
          check_field("lo_now", e.lo, lo_now);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_on() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus_proc
    int        r;
    req_type_e op;
    logic [31:0] a;
    logic [31:0] b;
    // reset values, then arithmetic extremes and the divide corner cases
    add_word(OP_MFHI, 32'hffffffff, 32'hffffffff);
    add_word(OP_MFLO, 32'd0, 32'd0);
    add_word(OP_MULT, 32'h80000000, 32'h80000000);
    add_word(OP_MULT, 32'hffffffff, 32'hffffffff);
    add_word(OP_MULT, 32'h7fffffff, 32'h80000000);
    add_word(OP_MULT, 32'd0, 32'hffffffff);
    add_word(OP_UMUL, 32'hffffffff, 32'hffffffff);
    add_word(OP_UMUL, 32'h80000000, 32'd2);
    add_word(OP_DIV, 32'd12345, 32'd0);
    add_word(OP_DIV, 32'd0, 32'd0, 1'b1);
    add_word(OP_DIV, 32'h80000000, 32'd0);
    add_word(OP_DIVU, 32'hfedcba98, 32'd0);
    add_word(OP_DIV, 32'h80000000, 32'hffffffff);
    add_word(OP_DIV, 32'hfffffff9, 32'd2);
    add_word(OP_DIV, 32'd7, 32'hfffffffe);
    add_word(OP_DIV, 32'hfffffff9, 32'hfffffffe);
    add_word(OP_DIVU, 32'hffffffff, 32'd1);
    add_word(OP_DIVU, 32'd5, 32'hffffffff);
    add_word(OP_MTHI, 32'ha5a5a5a5, 32'hffffffff);
    add_word(OP_MTLO, 32'h5a5a5a5a, 32'h12345678);
    add_word(OP_MFHI, 32'h13579bdf, 32'h2468ace0);
    add_word(OP_MFLO, 32'hffffffff, 32'h0);
    add_word(OP_MTHI, 32'd0, 32'd0);
    add_word(OP_MFHI, 32'd0, 32'd0);
    // random part: compute-then-read and write-then-read sequences, and single words
    while (pending_q.size() < NUM_RANDOM + 24) begin
      r = $urandom_range(0, 9);
      a = pick_operand();
      b = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_operand();
      if (r < 4) begin
        op = req_type_e'($urandom_range(0, 3));
        add_word(op, a, b, $urandom_range(0, 99) == 0);
        add_word(OP_MFHI, $urandom(), $urandom());
        add_word(OP_MFLO, $urandom(), $urandom());
      end else if (r < 6) begin
        add_word(req_type_e'($urandom_range(4, 5)), a, $urandom());
        add_word(req_type_e'($urandom_range(6, 7)), $urandom(), $urandom());
      end else begin
        add_word(req_type_e'($urandom_range(0, 7)), a, b);
      end
    end
    n_total = pending_q.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_results < n_total) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
